// File: sv/chb_pkg.sv
// ----------------------------------------------------------------------------
// chb_pkg
// Shared widths, register codes and the stage payload type of the
// Chebyshev series evaluator.
// ----------------------------------------------------------------------------
package chb_pkg;

    localparam int XW     = 32;   // Q16.16 sample, coefficient and result
    localparam int UW     = 32;   // Q4.28 mapped argument
    localparam int SPW    = 31;   // unsigned Q1.30 span scale
    localparam int TW     = 46;   // T_k with 28 fraction bits
    localparam int SW     = 52;   // running sum, Q.16
    localparam int FRAC_U = 28;
    localparam int NCOEF  = 5;
    localparam int AW     = 5;    // APB byte address

    typedef enum logic [2:0] {
        REG_CENTER = 3'd0,
        REG_SPAN   = 3'd1,
        REG_COEF0  = 3'd2,
        REG_COEF1  = 3'd3,
        REG_COEF2  = 3'd4,
        REG_COEF3  = 3'd5,
        REG_COEF4  = 3'd6
    } t_reg_idx;

    localparam logic signed [TW-1:0] T_ONE =
        {{(TW-FRAC_U-1){1'b0}}, 1'b1, {FRAC_U{1'b0}}};

    typedef struct packed {
        logic signed [UW-1:0] u;
        logic signed [TW-1:0] t_prev;
        logic signed [TW-1:0] t_cur;
        logic signed [SW-1:0] acc;
        logic                 sat;
    } t_step;

endpackage

// File: sv/chb_in_if.sv
// ----------------------------------------------------------------------------
// chb_in_if
// Sample channel: one x_value per beat.
// ----------------------------------------------------------------------------
interface chb_in_if import chb_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic signed [XW-1:0] x_value;

    modport source (output valid, output x_value, input ready);
    modport sink   (input valid, input x_value, output ready);

endinterface

// File: sv/chb_out_if.sv
// ----------------------------------------------------------------------------
// chb_out_if
// Result channel: series value and saturation flag per beat.
// ----------------------------------------------------------------------------
interface chb_out_if import chb_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic signed [XW-1:0] y_value;
    logic                 saturated;

    modport source (output valid, output y_value, output saturated, input ready);
    modport sink   (input valid, input y_value, input saturated, output ready);

endinterface

// File: sv/chb_map.sv
// ----------------------------------------------------------------------------
// chb_map
// Three-stage range mapping: difference, scale multiply, round and clamp
// to Q4.28. Seeds the recurrence with T0, T1 and the c0 term.
// ----------------------------------------------------------------------------
module chb_map import chb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_center,
    input  logic [SPW-1:0]        i_span,
    input  logic signed [XW-1:0]  i_coef0,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_step                 o_data
);

    logic                 r_v1, r_v2, r_v3;
    logic signed [XW:0]   r_diff;
    logic signed [63:0]   r_prod;
    t_step                r_data;

    logic                 w_en1, w_en2, w_en3;
    logic signed [64:0]   w_prod;
    logic signed [63:0]   w_round;
    logic signed [45:0]   w_ufull;
    logic                 w_ovf;
    t_step                n_data;

    assign w_en3   = !r_v3 || i_ready;
    assign w_en2   = !r_v2 || w_en3;
    assign w_en1   = !r_v1 || w_en2;
    assign o_ready = w_en1;

    assign w_prod  = r_diff * $signed({1'b0, i_span});
    assign w_round = r_prod + 64'sd131072;
    assign w_ufull = w_round[63:18];
    assign w_ovf   = !((&w_ufull[45:31]) || !(|w_ufull[45:31]));

    always_comb begin
        n_data.t_prev = T_ONE;
        n_data.acc    = SW'(i_coef0);
        n_data.sat    = w_ovf;
        if (w_ovf) begin
            n_data.u = w_ufull[45] ? {1'b1, {(UW-1){1'b0}}} : {1'b0, {(UW-1){1'b1}}};
        end else begin
            n_data.u = w_ufull[UW-1:0];
        end
        n_data.t_cur = TW'(n_data.u);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_valid) r_diff <= {i_x[XW-1], i_x} - {i_center[XW-1], i_center};
        if (w_en2 && r_v1)    r_prod <= w_prod[63:0];
        if (w_en3 && r_v2)    r_data <= n_data;
    end

    assign o_valid = r_v3;
    assign o_data  = r_data;

endmodule

// File: sv/chb_step.sv
// ----------------------------------------------------------------------------
// chb_step
// One recurrence step in two stages: partial products of c_k*T_k and
// 2u*T_k, then term accumulation and T(k+1) = 2u*T(k) - T(k-1).
// ----------------------------------------------------------------------------
module chb_step import chb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_step                 i_data,
    input  logic signed [XW-1:0]  i_coef,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_step                 o_data
);

    logic                 r_vm, r_vs;
    t_step                r_m, r_s;
    logic signed [61:0]   r_cl;
    logic signed [49:0]   r_ch;
    logic signed [62:0]   r_ul;
    logic signed [50:0]   r_uh;

    logic                 w_enm, w_ens;
    logic signed [17:0]   w_th;
    logic signed [28:0]   w_tl;
    logic signed [UW:0]   w_u2;
    logic signed [61:0]   w_cl;
    logic signed [49:0]   w_ch;
    logic signed [62:0]   w_ul;
    logic signed [50:0]   w_uh;
    logic signed [33:0]   w_cl_sh;
    logic signed [34:0]   w_ul_sh;
    logic signed [51:0]   w_tn;
    t_step                n_s;

    assign w_ens   = !r_vs || i_ready;
    assign w_enm   = !r_vm || w_ens;
    assign o_ready = w_enm;

    // T split as hi*2^28 + lo, lo unsigned
    assign w_th = i_data.t_cur[TW-1:FRAC_U];
    assign w_tl = {1'b0, i_data.t_cur[FRAC_U-1:0]};
    assign w_u2 = {i_data.u, 1'b0};

    assign w_cl = i_coef * w_tl + 62'sd134217728;
    assign w_ch = i_coef * w_th;
    assign w_ul = w_u2 * w_tl + 63'sd134217728;
    assign w_uh = w_u2 * w_th;

    assign w_cl_sh = r_cl[61:FRAC_U];
    assign w_ul_sh = r_ul[62:FRAC_U];
    assign w_tn    = r_uh + w_ul_sh - r_m.t_prev;

    always_comb begin
        n_s        = r_m;
        n_s.acc    = r_m.acc + r_ch + w_cl_sh;
        n_s.t_prev = r_m.t_cur;
        n_s.t_cur  = w_tn[TW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
            r_vs <= 1'b0;
        end else begin
            if (w_enm) r_vm <= i_valid;
            if (w_ens) r_vs <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_enm && i_valid) begin
            r_m  <= i_data;
            r_cl <= w_cl;
            r_ch <= w_ch;
            r_ul <= w_ul;
            r_uh <= w_uh;
        end
        if (w_ens && r_vm) r_s <= n_s;
    end

    assign o_valid = r_vs;
    assign o_data  = r_s;

endmodule

// File: sv/chb_out.sv
// ----------------------------------------------------------------------------
// chb_out
// Result clamp to Q16.16 and output register holding the beat until taken.
// ----------------------------------------------------------------------------
module chb_out import chb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_step                 i_data,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [XW-1:0]  o_y,
    output logic                  o_sat
);

    logic                 r_v;
    logic signed [XW-1:0] r_y;
    logic                 r_sat;

    logic                 w_en;
    logic                 w_ovf;
    logic signed [XW-1:0] n_y;

    assign w_en    = !r_v || i_ready;
    assign o_ready = w_en;
    assign w_ovf   = !((&i_data.acc[SW-1:XW-1]) || !(|i_data.acc[SW-1:XW-1]));

    always_comb begin
        if (w_ovf) begin
            n_y = i_data.acc[SW-1] ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
        end else begin
            n_y = i_data.acc[XW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (w_en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && i_valid) begin
            r_y   <= n_y;
            r_sat <= i_data.sat || w_ovf;
        end
    end

    assign o_valid = r_v;
    assign o_y     = r_y;
    assign o_sat   = r_sat;

endmodule

// File: sv/chebyshev_series_evaluator.sv
// ----------------------------------------------------------------------------
// chebyshev_series_evaluator
// Evaluates sum c_k T_k(u), u = (x - center) * inv_half_span, per sample.
//
// i_in carries one Q16.16 sample per beat; o_out returns one Q16.16 value
// and a saturation flag per sample, in order. Registers sit on an APB
// port at byte address 4*i: center, inv_half_span, coef_0..coef_4.
// The user must make writes only while no sample is in flight; the block
// itself does not enforce this. The pipe has three mapping stages, two per
// recurrence step (multiply, accumulate) and one output register.
// Throughput: one sample per cycle while o_out is not stalled; every stage
// is a pipeline register. Reset clears all stage valids and loads the
// register defaults. A stalled receiver holds the output beat; stages
// upstream keep filling bubbles and i_in.ready drops only once the whole
// pipe is full.
// ----------------------------------------------------------------------------
module chebyshev_series_evaluator import chb_pkg::*; #(
    parameter int DEGREE = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    chb_in_if.sink           i_in,
    chb_out_if.source        o_out,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AW-1:0]    paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic signed [XW-1:0] r_center;
    logic [SPW-1:0]       r_span;
    logic signed [XW-1:0] r_coef [NCOEF];

    logic                 w_wr;
    t_reg_idx             w_idx;
    t_step                w_stp [DEGREE+1];
    logic                 w_v   [DEGREE+1];
    logic                 w_rdy [DEGREE+1];

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = t_reg_idx'(paddr[AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= 32'sd46858240;
            r_span   <= 31'd2084936;
            for (int i = 0; i < NCOEF; i++) begin
                r_coef[i] <= '0;
            end
        end else if (w_wr) begin
            unique case (w_idx)
                REG_CENTER: r_center  <= pwdata;
                REG_SPAN:   r_span    <= pwdata[SPW-1:0];
                REG_COEF0:  r_coef[0] <= pwdata;
                REG_COEF1:  r_coef[1] <= pwdata;
                REG_COEF2:  r_coef[2] <= pwdata;
                REG_COEF3:  r_coef[3] <= pwdata;
                REG_COEF4:  r_coef[4] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_CENTER: prdata = r_center;
            REG_SPAN:   prdata = {1'b0, r_span};
            REG_COEF0:  prdata = r_coef[0];
            REG_COEF1:  prdata = r_coef[1];
            REG_COEF2:  prdata = r_coef[2];
            REG_COEF3:  prdata = r_coef[3];
            REG_COEF4:  prdata = r_coef[4];
            default:    prdata = '0;
        endcase
    end

    chb_map u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_x      (i_in.x_value),
        .i_center (r_center),
        .i_span   (r_span),
        .i_coef0  (r_coef[0]),
        .o_valid  (w_v[0]),
        .i_ready  (w_rdy[0]),
        .o_data   (w_stp[0])
    );

    for (genvar k = 1; k <= DEGREE; k++) begin : g_step
        chb_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_v[k-1]),
            .o_ready (w_rdy[k-1]),
            .i_data  (w_stp[k-1]),
            .i_coef  (r_coef[k]),
            .o_valid (w_v[k]),
            .i_ready (w_rdy[k]),
            .o_data  (w_stp[k])
        );
    end

    chb_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v[DEGREE]),
        .o_ready (w_rdy[DEGREE]),
        .i_data  (w_stp[DEGREE]),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_y     (o_out.y_value),
        .o_sat   (o_out.saturated)
    );

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for chebyshev_series_evaluator. A queue-fed driver
// sends samples with random idle bursts while the monitor stalls the result
// channel at random. Each accepted sample is run through a bit-exact
// predictor of the range mapping, the Chebyshev recurrence, the rounding and
// the clamps. Results are checked in order. Register settings change between
// drained phases, from directed corner cases to randomized extremes.
// ----------------------------------------------------------------------------
module tb import chb_pkg::*; ();

    localparam int DEGREE = 4;
    localparam int LATENCY = 2 * DEGREE + 4;
    localparam logic [2:0] REG_IDX_UNUSED = 3'd7;

    typedef logic signed [95:0] t_wide;
    typedef logic signed [XW-1:0] t_coef_set [NCOEF];

    typedef struct packed {
        logic signed [XW-1:0] y_value;
        logic                 saturated;
    } t_series;

    localparam t_wide Q_MAX = 2147483647;
    localparam t_wide Q_MIN = -Q_MAX - 1;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    chb_in_if  in_ch ();
    chb_out_if out_ch ();

    chebyshev_series_evaluator #(.DEGREE(DEGREE)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic signed [XW-1:0] map_center;
    logic [SPW-1:0]       map_scale;
    logic signed [XW-1:0] series_coef [NCOEF];

    logic signed [XW-1:0] sample_q [$];
    t_series              series_expect_q [$];
    t_series              expect_head;

    int src_idle_pct;
    int snk_idle_pct;
    int src_gap;
    int snk_gap;
    int err_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_wide q28_round(input t_wide a, input t_wide b);
        return (a * b + (t_wide'(1) <<< 27)) >>> FRAC_U;
    endfunction

    function automatic t_series eval_series(input logic signed [XW-1:0] x);
        t_wide xw, cw, sw, kw, u, t_prev, t_cur, t_next, acc;
        t_series r;
        int k;
        xw = t_wide'(x);
        cw = t_wide'(map_center);
        sw = t_wide'(map_scale);
        u = ((xw - cw) * sw + (t_wide'(1) <<< 17)) >>> 18;
        r.saturated = 1'b0;
        if (u > Q_MAX) begin
            u = Q_MAX;
            r.saturated = 1'b1;
        end
        if (u < Q_MIN) begin
            u = Q_MIN;
            r.saturated = 1'b1;
        end
        t_prev = t_wide'(1) <<< FRAC_U;
        t_cur = u;
        kw = t_wide'(series_coef[0]);
        acc = kw;
        for (k = 1; k <= DEGREE; k++) begin
            kw = t_wide'(series_coef[k]);
            acc += q28_round(kw, t_cur);
            t_next = q28_round(2 * u, t_cur) - t_prev;
            t_prev = t_cur;
            t_cur = t_next;
        end
        if (acc > Q_MAX) begin
            acc = Q_MAX;
            r.saturated = 1'b1;
        end
        if (acc < Q_MIN) begin
            acc = Q_MIN;
            r.saturated = 1'b1;
        end
        r.y_value = acc[XW-1:0];
        return r;
    endfunction

    function automatic longint srand(input longint r);
        longint mag;
        mag = longint'($urandom) % (r + 1);
        return ($urandom_range(0, 1) == 1) ? -mag : mag;
    endfunction

    // offset that moves u by one unit, capped to what 32-bit samples can reach
    function automatic logic signed [XW-1:0] pick_x();
        longint reach, off;
        int m;
        if (map_scale == 0)
            reach = longint'(1) <<< 31;
        else
            reach = (longint'(1) <<< 46) / longint'(map_scale);
        if (reach > (longint'(1) <<< 31))
            reach = longint'(1) <<< 31;
        m = $urandom_range(0, 99);
        if (m < 50)
            off = srand(reach);
        else if (m < 70)
            off = srand(reach * 8);
        else if (m < 80)
            off = (($urandom_range(0, 1) == 1) ? -reach * 8 : reach * 8) + srand(4);
        else
            return $urandom;
        off = longint'(map_center) + off;
        return off[XW-1:0];
    endfunction

    function automatic logic signed [XW-1:0] rand_coef(input bit full);
        longint v;
        if (full)
            return $urandom;
        v = srand(longint'(1) <<< 20);
        return v[XW-1:0];
    endfunction

    task automatic queue_sample(input logic signed [XW-1:0] x);
        sample_q.insert(sample_q.size(), x);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= AW'(idx) << 2;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx) inside
            REG_CENTER: map_center = data;
            REG_SPAN:   map_scale = data[SPW-1:0];
            REG_COEF0, REG_COEF1, REG_COEF2, REG_COEF3, REG_COEF4:
                series_coef[idx - REG_COEF0] = data;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || in_ch.valid || series_expect_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic apply_config(input logic [31:0] ctr, input logic [SPW-1:0] spn,
                                input t_coef_set cs);
        int k;
        wait_drained();
        cfg_write(REG_CENTER, ctr);
        cfg_write(REG_SPAN, {1'b0, spn});
        for (k = 0; k < NCOEF; k++)
            cfg_write(3'(REG_COEF0 + k), cs[k]);
        cfg_write(REG_IDX_UNUSED, $urandom);
        @(negedge i_clk);
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                series_expect_q.insert(series_expect_q.size(),
                                       eval_series(in_ch.x_value));
            if (!in_ch.valid || in_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
                    src_gap <= $urandom_range(0, 13);
                    in_ch.valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    in_ch.valid <= 1'b1;
                    in_ch.x_value <= sample_q.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            snk_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (series_expect_q.size() == 0) begin
                    $error("unexpected result beat: y_value %0d saturated %0b",
                           out_ch.y_value, out_ch.saturated);
                    err_count++;
                end else begin
                    expect_head = series_expect_q.pop_front();
                    if (out_ch.y_value !== expect_head.y_value) begin
                        $error("y_value: expected %0d, got %0d",
                               expect_head.y_value, out_ch.y_value);
                        err_count++;
                    end
                    if (out_ch.saturated !== expect_head.saturated) begin
                        $error("saturated: expected %0b, got %0b",
                               expect_head.saturated, out_ch.saturated);
                        err_count++;
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (snk_idle_pct > 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                snk_gap <= $urandom_range(0, 13);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_coef_set cs;
        logic signed [XW-1:0] ctr;
        logic [SPW-1:0] spn;
        int p, k, n;

        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.x_value = '0;
        out_ch.ready = 1'b0;
        err_count = 0;
        src_idle_pct = 10;
        snk_idle_pct = 10;
        map_center = 32'sd46858240;
        map_scale = 31'd2084936;
        for (k = 0; k < NCOEF; k++)
            series_coef[k] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values: all-zero series, u clamps far from center
        queue_sample(32'sd46858240);
        queue_sample(32'sd0);
        queue_sample(32'sh7fff_ffff);

        // unit scale: u equals x, mixed coefficients
        cs = '{32'sd65536, 32'sd32768, -32'sd16384, 32'sd131072, -32'sd65536};
        apply_config(32'sd0, 31'h4000_0000, cs);
        queue_sample(32'sd0);
        queue_sample(32'sd65536);
        queue_sample(-32'sd65536);
        queue_sample(32'sd32768);
        queue_sample(-32'sd32768);
        queue_sample(32'sd1);
        queue_sample(32'sd524287);
        queue_sample(32'sd524288);
        queue_sample(-32'sd524288);
        queue_sample(-32'sd524289);
        queue_sample(32'sh7fff_ffff);
        queue_sample(32'sh8000_0000);

        // result overflow in both directions
        cs = '{default: 32'sh7fff_ffff};
        apply_config(32'sd0, 31'h4000_0000, cs);
        queue_sample(32'sd32768);
        queue_sample(32'sd524288);
        queue_sample(-32'sd524288);
        cs = '{default: 32'sh8000_0000};
        apply_config(32'sh8000_0000, 31'h7fff_ffff, cs);
        queue_sample(32'sh8000_0000);
        queue_sample(32'sh7fff_ffff);
        queue_sample(32'sd0);

        for (p = 0; p < 8; p++) begin
            ctr = rand_coef(1'b0) <<< 6;
            spn = SPW'($urandom);
            for (k = 0; k < NCOEF; k++)
                cs[k] = rand_coef(1'b0);
            src_idle_pct = 10;
            snk_idle_pct = 10;
            case (p)
                1: begin
                    spn = '0;
                    for (k = 0; k < NCOEF; k++)
                        cs[k] = rand_coef(1'b1);
                end
                2: begin
                    ctr = 32'sh8000_0000;
                    spn = 31'h7fff_ffff;
                    src_idle_pct = 0;
                end
                3: begin
                    ctr = 32'sh7fff_ffff;
                    spn = SPW'($urandom_range(1, 1 << 16));
                    for (k = 0; k < NCOEF; k++)
                        cs[k] = rand_coef(1'b1);
                    snk_idle_pct = 30;
                end
                4: begin
                    ctr = '0;
                    cs = '{default: 32'sh7fff_ffff};
                end
                5: begin
                    cs = '{default: 32'sh8000_0000};
                    src_idle_pct = 40;
                    snk_idle_pct = 40;
                end
                6: begin
                    spn = SPW'($urandom_range(1 << 20, 1 << 28));
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                7: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
                default: ;
            endcase
            apply_config(ctr, spn, cs);
            for (n = 0; n < 69; n++)
                queue_sample(pick_x());
        end

        wait_drained();
        repeat (LATENCY + 8) @(posedge i_clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
